// ===== hdl/cftu_pkg.sv =====
// Shared types and constants for the continued-fraction trig unit.
// Holds beat structs, operation codes and fixed-point format constants; no dependencies.
package cftu_pkg;

    localparam int CF_TOP_TERM      = 19;
    localparam int ANGLE_FRAC_BITS  = 24;
    localparam int RESULT_FRAC_BITS = 32;

    // working fraction bits for all continued-fraction and half-angle math
    localparam int WF          = 31;
    localparam int CF_STEPS    = (CF_TOP_TERM - 1) / 2;
    localparam int CF_DEN_W    = $clog2(CF_TOP_TERM + 1) + WF;
    localparam int RED_Q       = 41;
    localparam int MAG_W       = 49;
    localparam int ANGLE_SHIFT = RED_Q - ANGLE_FRAC_BITS;
    localparam int K_W         = 9;
    localparam int VALUE_W     = 48;
    localparam int T_W         = 32;

    localparam logic [31:0]        TWO_OVER_PI_Q32 = 32'hA2F9836E;
    localparam logic [MAG_W-1:0]   HALF_PI_Q41     = 49'h3243F6A8886;
    localparam logic [11:0]        CW_HI           = 12'd3217;
    localparam logic [24:0]        CW_LO_Q42       = 25'd19590901;
    localparam logic [VALUE_W-1:0] VMAX            = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef enum logic [1:0] {
        OP_TAN = 2'd0,
        OP_SIN = 2'd1,
        OP_COS = 2'd2,
        OP_OMC = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]          req_type;
        logic signed [31:0]  angle;
    } t_in_beat;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      overflow;
    } t_out_beat;

    // per-item control that rides along with the tangent
    typedef struct packed {
        t_op  op;
        logic tneg;
        logic kodd;
    } t_trig_info;

endpackage

// ===== hdl/cftu_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Computes floor(num / den) given num >> QW < den; uses no package items.
module cftu_div #(
    parameter int NW = 63,
    parameter int DW = 36,
    parameter int QW = 31,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    function automatic logic [DW+QW-1:0] div_step(
        logic [DW-1:0] rem,
        logic [QW-1:0] nq,
        logic [DW-1:0] den
    );
        logic [DW:0] trial;
        logic [DW:0] diff;
        trial = {rem, nq[QW-1]};
        diff  = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            div_step = {diff[DW-1:0], nq[QW-2:0], 1'b1};
        end else begin
            div_step = {trial[DW-1:0], nq[QW-2:0], 1'b0};
        end
    endfunction

    logic          r_vld  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_nq   [QW];
    logic [DW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];

    logic          w_vin  [QW];
    logic [DW-1:0] w_rin  [QW];
    logic [QW-1:0] w_nin  [QW];
    logic [DW-1:0] w_din  [QW];
    logic [SW-1:0] w_sin  [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        if (g == 0) begin : g_first
            assign w_vin[g] = i_valid;
            assign w_rin[g] = DW'(i_num >> QW);
            assign w_nin[g] = i_num[QW-1:0];
            assign w_din[g] = i_den;
            assign w_sin[g] = i_side;
        end else begin : g_next
            assign w_vin[g] = r_vld[g-1];
            assign w_rin[g] = r_rem[g-1];
            assign w_nin[g] = r_nq[g-1];
            assign w_din[g] = r_den[g-1];
            assign w_sin[g] = r_side[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vin[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                {r_rem[g], r_nq[g]} <= div_step(w_rin[g], w_nin[g], w_din[g]);
                r_den[g]            <= w_din[g];
                r_side[g]           <= w_sin[g];
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_nq[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== hdl/cftu_reduce.sv =====
// Argument reduction: nearest multiple k of pi/2, Cody-Waite remainder, r^2.
// Depends on cftu_pkg; seven register stages.
module cftu_reduce
    import cftu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_in_beat    i_beat,
    output logic        o_valid,
    output t_trig_info  o_info,
    output logic [31:0] o_rw,
    output logic [31:0] o_x2
);

    localparam int M16_W  = MAG_W - (RED_Q - 16);
    localparam int PROD_W = M16_W + 32;
    localparam int KH_W   = K_W + 12;
    localparam int KL_W   = K_W + 25;
    localparam int R_W    = 54;
    localparam int SH_LO  = RED_Q - WF;

    // stage A: magnitude of the angle in Q41
    logic [31:0]      w_raw;
    logic [31:0]      w_am;
    logic             r_a_vld;
    t_op              r_a_op;
    logic             r_a_neg;
    logic [MAG_W-1:0] r_a_m41;

    assign w_raw = i_beat.angle;
    assign w_am  = w_raw[31] ? (~w_raw + 32'd1) : w_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_op  <= t_op'(i_beat.req_type);
            r_a_neg <= w_raw[31];
            r_a_m41 <= MAG_W'(w_am) << ANGLE_SHIFT;
        end
    end

    // stage B: pick the reduced argument per operation
    logic             n_b_q42;
    logic             n_b_sgn;
    logic [MAG_W-1:0] n_b_mag;
    logic [MAG_W-1:0] w_hp_sub;
    logic [MAG_W-1:0] w_sub_hp;
    logic             r_b_vld;
    t_op              r_b_op;
    logic             r_b_q42;
    logic             r_b_sgn;
    logic [MAG_W-1:0] r_b_mag;

    assign w_hp_sub = HALF_PI_Q41 - r_a_m41;
    assign w_sub_hp = r_a_m41 - HALF_PI_Q41;

    always_comb begin
        n_b_q42 = 1'b1;
        n_b_sgn = 1'b0;
        n_b_mag = r_a_m41;
        case (r_a_op)
            OP_TAN: begin
                n_b_q42 = 1'b0;
                n_b_sgn = r_a_neg;
            end
            OP_SIN: begin
                n_b_sgn = r_a_neg;
            end
            OP_COS: begin
                // cos(x) = sin(pi/2 - |x|)
                if (HALF_PI_Q41 >= r_a_m41) begin
                    n_b_mag = w_hp_sub;
                end else begin
                    n_b_mag = w_sub_hp;
                    n_b_sgn = 1'b1;
                end
            end
            OP_OMC: begin
                n_b_sgn = 1'b0;
            end
            default: begin
                n_b_sgn = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_op  <= r_a_op;
            r_b_q42 <= n_b_q42;
            r_b_sgn <= n_b_sgn;
            r_b_mag <= n_b_mag;
        end
    end

    // stage C: k = round(|x| * 2/pi) from the Q16 magnitude
    logic [M16_W-1:0]  w_m16;
    logic [PROD_W-1:0] w_prod;
    logic              r_c_vld;
    t_op               r_c_op;
    logic              r_c_q42;
    logic              r_c_sgn;
    logic [MAG_W-1:0]  r_c_mag;
    logic [K_W-1:0]    r_c_k;

    assign w_m16  = r_b_q42 ? M16_W'(r_b_mag >> (RED_Q + 1 - 16))
                            : M16_W'(r_b_mag >> (RED_Q - 16));
    assign w_prod = PROD_W'(w_m16) * PROD_W'(TWO_OVER_PI_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_op  <= r_b_op;
            r_c_q42 <= r_b_q42;
            r_c_sgn <= r_b_sgn;
            r_c_mag <= r_b_mag;
            r_c_k   <= K_W'((w_prod + (PROD_W'(1) << 47)) >> 48);
        end
    end

    // stage D: k times both halves of pi/2
    logic [24:0]      w_lo;
    logic             r_d_vld;
    t_op              r_d_op;
    logic             r_d_q42;
    logic             r_d_sgn;
    logic             r_d_kodd;
    logic [MAG_W-1:0] r_d_mag;
    logic [KH_W-1:0]  r_d_kh;
    logic [KL_W-1:0]  r_d_kl;

    assign w_lo = r_c_q42 ? CW_LO_Q42 : (CW_LO_Q42 >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_op   <= r_c_op;
            r_d_q42  <= r_c_q42;
            r_d_sgn  <= r_c_sgn;
            r_d_kodd <= r_c_k[0];
            r_d_mag  <= r_c_mag;
            r_d_kh   <= KH_W'(r_c_k) * KH_W'(CW_HI);
            r_d_kl   <= KL_W'(r_c_k) * KL_W'(w_lo);
        end
    end

    // stage E: signed remainder r = |x| - k*hi + k*lo
    logic [R_W-1:0] w_khs;
    logic           r_e_vld;
    t_op            r_e_op;
    logic           r_e_q42;
    logic           r_e_sgn;
    logic           r_e_kodd;
    logic [R_W-1:0] r_e_r;

    assign w_khs = r_d_q42 ? (R_W'(r_d_kh) << (RED_Q + 1 - 11))
                           : (R_W'(r_d_kh) << (RED_Q - 11));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (i_en) begin
            r_e_vld <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_op   <= r_d_op;
            r_e_q42  <= r_d_q42;
            r_e_sgn  <= r_d_sgn;
            r_e_kodd <= r_d_kodd;
            r_e_r    <= R_W'(r_d_mag) + R_W'(r_d_kl) - w_khs;
        end
    end

    // stage F: round |r| half up to Q31
    logic [R_W-1:0] w_rm;
    logic [R_W-1:0] w_rsum;
    logic [R_W-1:0] w_rsh;
    logic           r_f_vld;
    t_trig_info     r_f_info;
    logic [31:0]    r_f_rw;

    assign w_rm   = r_e_r[R_W-1] ? (~r_e_r + R_W'(1)) : r_e_r;
    assign w_rsum = w_rm + (r_e_q42 ? (R_W'(1) << SH_LO) : (R_W'(1) << (SH_LO - 1)));
    assign w_rsh  = r_e_q42 ? (w_rsum >> (SH_LO + 1)) : (w_rsum >> SH_LO);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (i_en) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_info.op   <= r_e_op;
            r_f_info.tneg <= r_e_sgn ^ r_e_r[R_W-1];
            r_f_info.kodd <= r_e_kodd;
            r_f_rw        <= w_rsh[31:0];
        end
    end

    // stage G: r^2 in Q31
    logic [63:0] w_sq;
    logic        r_g_vld;
    t_trig_info  r_g_info;
    logic [31:0] r_g_rw;
    logic [31:0] r_g_x2;

    assign w_sq = 64'(r_f_rw) * 64'(r_f_rw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_vld <= 1'b0;
        end else if (i_en) begin
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g_info <= r_f_info;
            r_g_rw   <= r_f_rw;
            r_g_x2   <= 32'(w_sq >> WF);
        end
    end

    assign o_valid = r_g_vld;
    assign o_info  = r_g_info;
    assign o_rw    = r_g_rw;
    assign o_x2    = r_g_x2;

endmodule

// ===== hdl/cftu_cf.sv =====
// Lambert continued fraction for tan(r), one pipelined divider per term.
// Depends on cftu_pkg and cftu_div.
module cftu_cf
    import cftu_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_trig_info     i_info,
    input  logic [31:0]    i_rw,
    input  logic [31:0]    i_x2,
    output logic           o_valid,
    output t_trig_info     o_info,
    output logic [T_W-1:0] o_t
);

    typedef struct packed {
        t_trig_info  info;
        logic [31:0] rw;
        logic [31:0] x2;
    } t_cf_side;

    localparam int SIDE_W = $bits(t_cf_side);
    localparam int INFO_W = $bits(t_trig_info);

    logic              w_dv  [CF_STEPS];
    logic [WF-1:0]     w_dq  [CF_STEPS];
    logic [SIDE_W-1:0] w_ds  [CF_STEPS];

    // term i = CF_TOP_TERM - 2*j: tt = r^2 / (i - tt)
    for (genvar j = 0; j < CF_STEPS; j++) begin : g_term
        logic                w_vin;
        logic [WF-1:0]       w_tt;
        t_cf_side            w_sin;
        logic                r_vld;
        logic [CF_DEN_W-1:0] r_den;
        t_cf_side            r_side;

        if (j == 0) begin : g_head
            assign w_vin = i_valid;
            assign w_tt  = '0;
            assign w_sin = '{info: i_info, rw: i_rw, x2: i_x2};
        end else begin : g_tail
            assign w_vin = w_dv[j-1];
            assign w_tt  = w_dq[j-1];
            assign w_sin = t_cf_side'(w_ds[j-1]);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den  <= (CF_DEN_W'(CF_TOP_TERM - 2 * j) << WF) - CF_DEN_W'(w_tt);
                r_side <= w_sin;
            end
        end

        cftu_div #(
            .NW (WF + 32),
            .DW (CF_DEN_W),
            .QW (WF),
            .SW (SIDE_W)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (r_vld),
            .i_num   ({r_side.x2, {WF{1'b0}}}),
            .i_den   (r_den),
            .i_side  (r_side),
            .o_valid (w_dv[j]),
            .o_quo   (w_dq[j]),
            .o_side  (w_ds[j])
        );
    end

    // t = r / (1 - tt)
    t_cf_side          w_last;
    logic              r_fv;
    logic [T_W-1:0]    r_fden;
    t_trig_info        r_finfo;
    logic [31:0]       r_frw;
    logic [INFO_W-1:0] w_oinfo;

    assign w_last = t_cf_side'(w_ds[CF_STEPS-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_fv <= w_dv[CF_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fden  <= (T_W'(1) << WF) - T_W'(w_dq[CF_STEPS-1]);
            r_finfo <= w_last.info;
            r_frw   <= w_last.rw;
        end
    end

    cftu_div #(
        .NW (WF + 32),
        .DW (T_W),
        .QW (T_W),
        .SW (INFO_W)
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_fv),
        .i_num   ({r_frw, {WF{1'b0}}}),
        .i_den   (r_fden),
        .i_side  (r_finfo),
        .o_valid (o_valid),
        .o_quo   (o_t),
        .o_side  (w_oinfo)
    );

    assign o_info = t_trig_info'(w_oinfo);

endmodule

// ===== hdl/cftu_post.sv =====
// Final function step: tan/sin/cos/1-cos from the tangent, then scale and saturate.
// Depends on cftu_pkg and cftu_div.
module cftu_post
    import cftu_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  t_trig_info     i_info,
    input  logic [T_W-1:0] i_t,
    output logic           o_valid,
    output t_out_beat      o_beat
);

    localparam int NUM_W = 66;
    localparam int DEN_W = 34;
    localparam int QUO_W = VALUE_W - 1;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_HALF  = 2'd1,
        MODE_RECIP = 2'd2,
        MODE_POLE  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode          mode;
        logic           sign;
        logic           tiny;
        logic [T_W-1:0] t;
    } t_post_side;

    localparam int SIDE_W = $bits(t_post_side);

    // stage 1: t^2 in Q31
    logic [63:0]    w_tsq;
    logic           r_1_vld;
    t_trig_info     r_1_info;
    logic [T_W-1:0] r_1_t;
    logic [32:0]    r_1_sq;

    assign w_tsq = 64'(i_t) * 64'(i_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_1_vld <= 1'b0;
        end else if (i_en) begin
            r_1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_1_info <= i_info;
            r_1_t    <= i_t;
            r_1_sq   <= 33'(w_tsq >> WF);
        end
    end

    // stage 2: set up the last division
    logic [DEN_W-1:0] w_one_sq;
    logic [NUM_W-1:0] n_2_num;
    logic [DEN_W-1:0] n_2_den;
    t_post_side       n_2_side;
    logic             r_2_vld;
    logic [NUM_W-1:0] r_2_num;
    logic [DEN_W-1:0] r_2_den;
    t_post_side       r_2_side;

    assign w_one_sq = (DEN_W'(1) << WF) + DEN_W'(r_1_sq);

    always_comb begin
        n_2_num       = '0;
        n_2_den       = w_one_sq;
        n_2_side.mode = MODE_HALF;
        n_2_side.sign = 1'b0;
        n_2_side.tiny = 1'b0;
        n_2_side.t    = r_1_t;
        case (r_1_info.op)
            OP_TAN: begin
                if (!r_1_info.kodd) begin
                    n_2_side.mode = MODE_PASS;
                    n_2_side.sign = r_1_info.tneg;
                end else if (r_1_t == '0) begin
                    n_2_side.mode = MODE_POLE;
                end else begin
                    // -1/t; t at or below 2^-15 saturates
                    n_2_side.mode = MODE_RECIP;
                    n_2_side.sign = !r_1_info.tneg;
                    n_2_side.tiny = (r_1_t <= (T_W'(1) << (VALUE_W - 1 - WF)));
                    n_2_num       = NUM_W'(1) << (WF + RESULT_FRAC_BITS);
                    n_2_den       = DEN_W'(r_1_t);
                end
            end
            OP_SIN, OP_COS: begin
                n_2_side.sign = r_1_info.tneg ^ r_1_info.kodd;
                n_2_num       = NUM_W'(r_1_t) << (WF + 1);
            end
            OP_OMC: begin
                n_2_num = r_1_info.kodd ? (NUM_W'(1) << (WF + 1 + WF))
                                        : (NUM_W'(r_1_sq) << (WF + 1));
            end
            default: begin
                n_2_num = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_2_vld <= 1'b0;
        end else if (i_en) begin
            r_2_vld <= r_1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_2_num  <= n_2_num;
            r_2_den  <= n_2_den;
            r_2_side <= n_2_side;
        end
    end

    logic              w_dv;
    logic [QUO_W-1:0]  w_q;
    logic [SIDE_W-1:0] w_ds_raw;
    t_post_side        w_ds;

    cftu_div #(
        .NW (NUM_W),
        .DW (DEN_W),
        .QW (QUO_W),
        .SW (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_2_vld),
        .i_num   (r_2_num),
        .i_den   (r_2_den),
        .i_side  (r_2_side),
        .o_valid (w_dv),
        .o_quo   (w_q),
        .o_side  (w_ds_raw)
    );

    assign w_ds = t_post_side'(w_ds_raw);

    // stage 3: to Q16.32 with saturation and sign
    logic [VALUE_W-1:0] n_3_mag;
    logic               n_3_ovf;
    logic               r_3_vld;
    t_out_beat          r_3_beat;

    always_comb begin
        n_3_mag = VMAX;
        n_3_ovf = 1'b0;
        case (w_ds.mode)
            MODE_PASS: begin
                n_3_mag = VALUE_W'(w_ds.t) << 1;
            end
            MODE_HALF: begin
                if (w_q > QUO_W'(VMAX >> 1)) begin
                    n_3_ovf = 1'b1;
                end else begin
                    n_3_mag = {w_q, 1'b0};
                end
            end
            MODE_RECIP: begin
                if (w_ds.tiny) begin
                    n_3_ovf = 1'b1;
                end else begin
                    n_3_mag = {1'b0, w_q};
                end
            end
            MODE_POLE: begin
                n_3_ovf = 1'b1;
            end
            default: begin
                n_3_ovf = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_3_vld <= 1'b0;
        end else if (i_en) begin
            r_3_vld <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_3_beat.value    <= w_ds.sign ? (~n_3_mag + VALUE_W'(1)) : n_3_mag;
            r_3_beat.overflow <= n_3_ovf;
        end
    end

    assign o_valid = r_3_vld;
    assign o_beat  = r_3_beat;

endmodule

// ===== hdl/continued_fraction_trig_unit.sv =====
// Top level of the continued-fraction trig unit: reduction, fraction, finish, output skid.
// Depends on cftu_pkg, cftu_reduce, cftu_cf, cftu_post.
//
// Takes one beat per clock while o_ready is high (req_type 0 tan, 1 sin, 2 cos, 3 one
// minus cos, angle in Q8.24 radians) and returns one beat per clock while i_ready is
// high (value in Q16.32, overflow on a tan pole or saturation). The path from accept to
// output runs through 7 reduction stages, 9 continued-fraction terms at 32 stages each, 33
// stages for t = r/(1-tt), 50 finishing stages (47 of them the last divider) and the output
// register; the length is set by the restoring dividers, one quotient bit per stage. The
// pipeline advances as a whole; a two-entry output buffer lets o_ready stay high while one
// result waits, and drops it only once a second result is held.
module continued_fraction_trig_unit
    import cftu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_beat,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_beat
);

    logic           w_en;
    logic           w_rv;
    t_trig_info     w_rinfo;
    logic [31:0]    w_rw;
    logic [31:0]    w_x2;
    logic           w_cv;
    t_trig_info     w_cinfo;
    logic [T_W-1:0] w_t;
    logic           w_pv;
    t_out_beat      w_pbeat;
    logic           w_feed;
    logic           w_take;

    logic           r_ov;
    t_out_beat      r_od;
    logic           r_sv;
    t_out_beat      r_sd;

    // hold the whole pipeline once the skid entry is occupied
    assign w_en    = !r_sv;
    assign o_ready = w_en;

    cftu_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_beat  (i_beat),
        .o_valid (w_rv),
        .o_info  (w_rinfo),
        .o_rw    (w_rw),
        .o_x2    (w_x2)
    );

    cftu_cf u_cf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rv),
        .i_info  (w_rinfo),
        .i_rw    (w_rw),
        .i_x2    (w_x2),
        .o_valid (w_cv),
        .o_info  (w_cinfo),
        .o_t     (w_t)
    );

    cftu_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv),
        .i_info  (w_cinfo),
        .i_t     (w_t),
        .o_valid (w_pv),
        .o_beat  (w_pbeat)
    );

    assign w_feed = w_en && w_pv;
    assign w_take = r_ov && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || w_take) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= w_feed;
            end
        end else if (w_feed) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || w_take) begin
            r_od <= r_sv ? r_sd : w_pbeat;
        end
        if (w_feed && r_ov && !w_take) begin
            r_sd <= w_pbeat;
        end
    end

    assign o_valid = r_ov;
    assign o_beat  = r_od;

endmodule

// ===== hdl/cftu_chk.sv =====
// Port-level checks for the continued-fraction trig unit, bound to the top level.
// Depends on cftu_pkg.
module cftu_chk
    import cftu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_beat o_beat
);

    localparam logic [VALUE_W-1:0] NEG_VMAX = ~VMAX + VALUE_W'(1);
    localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_beat))
        else $error("output beat changed while stalled");

    a_ovf_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_beat.overflow |->
            (o_beat.value == VMAX) || (o_beat.value == NEG_VMAX))
        else $error("overflow flagged on an unclamped value");

    a_no_most_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_beat.value != MOST_NEG)
        else $error("most negative code produced");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with no result waiting");

endmodule

bind continued_fraction_trig_unit cftu_chk u_cftu_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_beat  (o_beat)
);
